// ----- src/sha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants, types and round functions for the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  typedef logic [31:0] word_t;

  // Transaction as classified by the front end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t start_hash(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- src/sha_item_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_item_fifo
// Short queue between the accepting front end and the hashing back end.
// ----------------------------------------------------------------------------
module sha_item_fifo #(
  parameter int unsigned Depth = sha_pkg::QueueDepthDefault
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sha_pkg::item_t  wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sha_pkg::item_t  rd_item
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::item_t  mem_r [Depth];
  logic [Aw-1:0]   wp_r, rp_r;
  logic [Aw:0]     cnt_r;

  function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
    return (p == Aw'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  wire do_wr = wr_valid && wr_ready;
  wire do_rd = rd_valid && rd_ready;

  assign wr_ready = (cnt_r != (Aw+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= inc(wp_r);
      if (do_rd) rp_r <= inc(rp_r);
      if (do_wr && !do_rd) cnt_r <= cnt_r + 1'b1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_item;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Aw+1)'(Depth)) else $error("queue count overflow");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (Aw+1)'(Depth)) && !do_rd |=> cnt_r == (Aw+1)'(Depth))
    else $error("queue lost an entry");
  a_empty_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !do_rd) else $error("read from empty queue");
endmodule

// ----- src/sha_core_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core_engine
// Back end: block buffer, padding, serial round unit and digest emission.
// ----------------------------------------------------------------------------
module sha_core_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  output logic            item_ready,
  input  sha_pkg::item_t  item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_digest_word,
  output logic [2:0]      out_word_index,
  output logic            out_last_word
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_MARK, ST_PAD, ST_LEN, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  state_t          state_r;
  logic [6:0]      fill_r;
  logic [63:0]     msg_r;
  sha_pkg::word_t  h_r [8];
  sha_pkg::word_t  v_r [8];
  sha_pkg::word_t  w_r [16];        // block bytes, then message schedule window
  logic [5:0]      rnd_r;
  logic            final_r;         // block being compressed ends the message
  logic            lenblk_r;        // length field goes in the current block
  logic            mark_r;          // 0x80 marker waits behind a full block
  logic            padp_r;          // zero fill carries on into the next block
  logic [2:0]      oidx_r;
  logic            ovalid_r;

  // byte-to-buffer write port
  logic            bwr;
  logic [5:0]      baddr;
  logic [7:0]      bdata;
  logic [63:0]     bit_len;

  assign item_ready = (state_r == ST_IDLE);
  assign bit_len    = {msg_r[60:0], 3'b000};

  // schedule and round datapath
  sha_pkg::word_t w_new, w_cur, s0, s1, t1, t2, e, a;
  always_comb begin
    s0 = sha_pkg::ror(w_r[1], 7) ^ sha_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha_pkg::ror(w_r[14], 17) ^ sha_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    w_cur = w_r[0];
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + sha_pkg::round_k(rnd_r) + w_cur;
    t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    bwr   = 1'b0;
    baddr = fill_r[5:0];
    bdata = item.data_byte;
    case (state_r)
      ST_IDLE: bwr = item_valid && item.byte_present;
      ST_MARK: begin
        bwr   = 1'b1;
        bdata = 8'h80;
      end
      ST_PAD: begin
        bwr   = 1'b1;
        bdata = 8'h00;
      end
      ST_LEN: begin
        bwr   = 1'b1;
        bdata = bit_len[{~fill_r[2:0], 3'b000} +: 8];
      end
      default: bwr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      msg_r    <= '0;
      final_r  <= 1'b0;
      lenblk_r <= 1'b0;
      mark_r   <= 1'b0;
      padp_r   <= 1'b0;
      oidx_r   <= '0;
      ovalid_r <= 1'b0;
      rnd_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::start_hash(3'(i));
    end else begin
      // big-endian byte lanes within each schedule word
      if (bwr) w_r[baddr[5:2]][{~baddr[1:0], 3'b000} +: 8] <= bdata;
      case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.byte_present) begin
              msg_r <= msg_r + 64'd1;
              if (fill_r[5:0] == 6'd63) begin
                fill_r  <= '0;
                final_r <= 1'b0;
                mark_r  <= item.end_of_message;
                state_r <= ST_LOAD;
              end else begin
                fill_r <= fill_r + 7'd1;
                if (item.end_of_message) state_r <= ST_MARK;
              end
            end else if (item.end_of_message) begin
              state_r <= ST_MARK;
            end
          end
        end
        ST_MARK: begin
          // 0x80 marker; room for the length decides the padding path
          if (fill_r[5:0] == 6'd63) begin
            fill_r  <= '0;
            final_r <= 1'b0;
            padp_r  <= 1'b1;
            state_r <= ST_LOAD;
          end else if (fill_r[5:0] == 6'd55) begin
            fill_r  <= 7'd56;
            state_r <= ST_LEN;
          end else begin
            fill_r   <= fill_r + 7'd1;
            lenblk_r <= (fill_r[5:0] < 6'd55);
            state_r  <= ST_PAD;
          end
        end
        ST_PAD: begin
          // zero fill; boundary 56 leads to the length, 64 to an extra block
          if (lenblk_r && fill_r[5:0] == 6'd55) begin
            fill_r  <= 7'd56;
            state_r <= ST_LEN;
          end else if (fill_r[5:0] == 6'd63) begin
            fill_r  <= '0;
            final_r <= 1'b0;
            padp_r  <= 1'b1;
            state_r <= ST_LOAD;
          end else begin
            fill_r <= fill_r + 7'd1;
          end
        end
        ST_LEN: begin
          if (fill_r[5:0] == 6'd63) begin
            fill_r   <= '0;
            final_r  <= 1'b1;
            lenblk_r <= 1'b0;
            state_r  <= ST_LOAD;
          end else begin
            fill_r <= fill_r + 7'd1;
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          rnd_r   <= '0;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
          if (final_r) begin
            oidx_r   <= '0;
            ovalid_r <= 1'b1;
            state_r  <= ST_EMIT;
          end else if (mark_r) begin
            // end of message arrived with the byte that filled the block
            mark_r  <= 1'b0;
            state_r <= ST_MARK;
          end else if (padp_r) begin
            padp_r   <= 1'b0;
            lenblk_r <= 1'b1;
            state_r  <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              ovalid_r <= 1'b0;
              final_r  <= 1'b0;
              fill_r   <= '0;
              msg_r    <= '0;
              for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::start_hash(3'(i));
              state_r  <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = ovalid_r;
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index)) else $error("digest word dropped or changed");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    item_ready |-> !out_valid) else $error("emitting while accepting");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_r[6]) else $error("fill count out of range");
endmodule

// ----- src/sha256_hash_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_core
// SHA-256 over a byte stream, one byte per transaction.
// ----------------------------------------------------------------------------
// Every 64th byte starts a block compression of one setup step, 64 rounds and
// one add, run by the single serial round unit. End of message writes the 0x80
// marker, zero fill and the length one byte a cycle, pausing for an extra block
// compression when the length no longer fits, compresses the final block and
// then offers eight digest words, word 0 first. A queue, four deep by default,
// lets the front accept transactions while the back end compresses.
module sha256_hash_engine_core #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha_pkg::item_t in_item, q_item;
  logic           q_valid, q_ready;

  assign in_item = '{data_byte: in_data_byte, byte_present: in_byte_present,
                     end_of_message: in_end_of_message};

  sha_item_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst_n,
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_item(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  sha_core_engine u_engine (
    .clk, .rst_n,
    .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );
endmodule
